// File: hdl/assert_macros.svh
// Assertion helpers; bodies vanish under SYNTHESIS.
// Both macros sample on clk and hold off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: hdl/kmac_pkg.sv
package kmac_pkg;

    localparam int unsigned CLK_W = 32;
    localparam int unsigned CNT_W = 7;   // counts up to 126 peers plus self
    localparam int unsigned NUM_CAP = 4;

    localparam logic [CLK_W-1:0] CLOCK_MAX = '1;

    // register byte addresses
    localparam logic [4:0] ADDR_NODE_COUNT = 5'd0;
    localparam logic [4:0] ADDR_SELF_ID    = 5'd4;
    localparam logic [4:0] ADDR_CAP0       = 5'd8;
    localparam logic [4:0] ADDR_CAP1       = 5'd12;
    localparam logic [4:0] ADDR_CAP2       = 5'd16;
    localparam logic [4:0] ADDR_CAP3       = 5'd20;

    typedef enum logic [1:0] {
        MODE_PEER_STATE = 2'd0,
        MODE_PEER_REQ   = 2'd1,
        MODE_OWN_REQ    = 2'd2,
        MODE_OWN_REL    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic [CLK_W-1:0] clock;
        logic [1:0]       channel;
        logic [CLK_W-1:0] rtime;
        logic             active;
    } peer_t;

    // token that walks the cell row
    typedef struct packed {
        logic             go;
        logic             ok;
        logic [CNT_W-1:0] cnt;
    } scan_t;

    function automatic logic [CLK_W-1:0] sat_inc(input logic [CLK_W-1:0] v);
        sat_inc = (v == CLOCK_MAX) ? CLOCK_MAX : v + CLK_W'(1);
    endfunction

endpackage

// File: hdl/k_mutex_admission_check_top.sv
// channel  | dir | handshake                   | moves
// ---------+-----+-----------------------------+------------------------------------------
// request  | in  | start && !busy              | mode, peer_id, peer_clock, peer_channel,
//          |     |                             | peer_request_time, peer_active,
//          |     |                             | request_channel
// result   | out | done (one cycle strobe)     | granted, clock_value, send_state, pending
// config   | in  | psel&penable&pwrite&pready  | node_count, self_id, channel_capacity_0..3
//
// From accept to the done strobe: the accept cycle updates the clock and the peer
// table, the LAUNCH state starts a token that walks the row of MAX_NODES cells,
// one cell per cycle, and done is registered as the token leaves the last cell.
// busy stays high from accept until done; a new request may be taken in the done cycle.
// rst_n is asynchronous, active low; it clears the clock, own request and peer table.
// The result side cannot stall: results are registered and shown for one cycle.
`include "assert_macros.svh"

module k_mutex_admission_check_top
    import kmac_pkg::*;
#(
    parameter int unsigned MAX_NODES    = 16,
    parameter int unsigned NUM_CHANNELS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [3:0]  peer_id,
    input  logic [31:0] peer_clock,
    input  logic [1:0]  peer_channel,
    input  logic [31:0] peer_request_time,
    input  logic        peer_active,
    input  logic [1:0]  request_channel,
    // result
    output logic        done,
    output logic        granted,
    output logic [31:0] clock_value,
    output logic        send_state,
    output logic        pending,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------- configuration registers ----------------
    logic [4:0] node_count_reg;
    logic [3:0] self_id_reg;
    logic [3:0] cap_reg [NUM_CAP];
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= 5'd1;
            self_id_reg    <= 4'd0;
            for (int i = 0; i < NUM_CAP; i++)
            begin
                cap_reg[i] <= 4'd1;
            end
        end
        else if (cfg_wr)
        begin
            unique case (paddr)
                ADDR_NODE_COUNT: node_count_reg <= pwdata[4:0];
                ADDR_SELF_ID:    self_id_reg    <= pwdata[3:0];
                ADDR_CAP0:       cap_reg[0]     <= pwdata[3:0];
                ADDR_CAP1:       cap_reg[1]     <= pwdata[3:0];
                ADDR_CAP2:       cap_reg[2]     <= pwdata[3:0];
                ADDR_CAP3:       cap_reg[3]     <= pwdata[3:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_NODE_COUNT: prdata = {27'd0, node_count_reg};
            ADDR_SELF_ID:    prdata = {28'd0, self_id_reg};
            ADDR_CAP0:       prdata = {28'd0, cap_reg[0]};
            ADDR_CAP1:       prdata = {28'd0, cap_reg[1]};
            ADDR_CAP2:       prdata = {28'd0, cap_reg[2]};
            ADDR_CAP3:       prdata = {28'd0, cap_reg[3]};
            default:         prdata = '0;
        endcase
    end

    // ---------------- control ----------------
    state_t state_reg;
    state_t state_next;
    logic   accept;
    mode_t  mode_in;
    scan_t  chain [MAX_NODES+1];
    logic   scan_end;

    assign accept   = start && !busy;
    assign mode_in  = mode_t'(mode);
    assign busy     = (state_reg != ST_IDLE);
    assign scan_end = chain[MAX_NODES].go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LAUNCH;
                end
            end
            ST_LAUNCH:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- own state and clock ----------------
    logic [CLK_W-1:0] clock_reg;
    logic [CLK_W-1:0] clock_next;
    logic [1:0]       own_channel_reg;
    logic [CLK_W-1:0] own_rtime_reg;
    logic             own_req_reg;
    logic             send_reg;
    logic [CLK_W-1:0] peer_step;
    logic             peer_mode;

    // channel codes past the channel count fold back
    function automatic logic [1:0] fold_ch(input logic [1:0] c);
        unique case (c)
            2'd0: fold_ch = 2'(32'd0 % NUM_CHANNELS);
            2'd1: fold_ch = 2'(32'd1 % NUM_CHANNELS);
            2'd2: fold_ch = 2'(32'd2 % NUM_CHANNELS);
            2'd3: fold_ch = 2'(32'd3 % NUM_CHANNELS);
        endcase
    endfunction

    assign peer_mode = (mode_in == MODE_PEER_STATE) || (mode_in == MODE_PEER_REQ);
    assign peer_step = sat_inc((peer_clock > clock_reg) ? peer_clock : clock_reg);

    always_comb
    begin
        unique case (mode_in)
            MODE_PEER_STATE: clock_next = peer_step;
            MODE_PEER_REQ:   clock_next = sat_inc(peer_step);   // reply tick
            MODE_OWN_REQ:    clock_next = sat_inc(clock_reg);
            MODE_OWN_REL:    clock_next = clock_reg;
            default:         clock_next = clock_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg       <= '0;
            own_channel_reg <= '0;
            own_rtime_reg   <= '0;
            own_req_reg     <= 1'b0;
            send_reg        <= 1'b0;
        end
        else if (accept)
        begin
            clock_reg <= clock_next;
            send_reg  <= (mode_in == MODE_PEER_REQ) || (mode_in == MODE_OWN_REQ);
            if (mode_in == MODE_OWN_REQ)
            begin
                own_channel_reg <= fold_ch(request_channel);
                own_rtime_reg   <= clock_next;
                own_req_reg     <= 1'b1;
            end
            else if (mode_in == MODE_OWN_REL)
            begin
                own_req_reg <= 1'b0;
            end
        end
    end

    // ---------------- cell row ----------------
    peer_t            wr_data;
    logic [MAX_NODES-1:0] go_vec;

    assign wr_data.clock   = peer_clock;
    assign wr_data.channel = fold_ch(peer_channel);
    assign wr_data.rtime   = peer_request_time;
    assign wr_data.active  = peer_active;

    // token enters cell 0 with the own request already counted
    assign chain[0].go  = (state_reg == ST_LAUNCH);
    assign chain[0].ok  = 1'b1;
    assign chain[0].cnt = CNT_W'(1);

    for (genvar i = 0; i < MAX_NODES; i++)
    begin : g_cell
        logic wr_en;
        logic incl;

        assign wr_en = accept && peer_mode && (32'(peer_id) == 32'(i));
        assign incl  = (32'(i) < 32'(node_count_reg)) && (32'(i) != 32'(self_id_reg));
        assign go_vec[i] = chain[i+1].go;

        kmac_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .wr_en       (wr_en),
            .wr_data     (wr_data),
            .incl        (incl),
            .own_rtime   (own_rtime_reg),
            .own_channel (own_channel_reg),
            .scan_in     (chain[i]),
            .scan_out    (chain[i+1])
        );
    end

    // ---------------- result ----------------
    logic done_reg;
    logic granted_reg;
    logic grant_now;

    assign grant_now = own_req_reg && chain[MAX_NODES].ok
                       && (chain[MAX_NODES].cnt <= CNT_W'(cap_reg[own_channel_reg]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            granted_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_SCAN) && scan_end;
            if ((state_reg == ST_SCAN) && scan_end)
            begin
                granted_reg <= grant_now;
            end
        end
    end

    assign done        = done_reg;
    assign granted     = granted_reg;
    assign clock_value = clock_reg;
    assign send_state  = send_reg;
    assign pending     = own_req_reg;

    // ---------------- checks ----------------
    `ASSERT_IMP(a_grant_needs_pending, done_reg && granted_reg, own_req_reg)
    `ASSERT_NXT(a_accept_goes_busy, accept, busy)
    `ASSERT_NXT(a_done_single, done_reg, !done_reg)
    `ASSERT_IMP(a_one_token, 1'b1, $onehot0(go_vec))

endmodule

// File: hdl/kmac_cell.sv
module kmac_cell
    import kmac_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  peer_t            wr_data,
    input  logic             incl,
    input  logic [CLK_W-1:0] own_rtime,
    input  logic [1:0]       own_channel,
    input  scan_t            scan_in,
    output scan_t            scan_out
);

    peer_t entry_reg;
    scan_t scan_reg;
    scan_t scan_next;
    logic  late;
    logic  hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (wr_en)
        begin
            entry_reg <= wr_data;
        end
    end

    always_comb
    begin
        late = entry_reg.clock > own_rtime;
        hit  = entry_reg.active && (entry_reg.channel == own_channel)
               && (entry_reg.rtime <= own_rtime);
        scan_next.go  = scan_in.go;
        scan_next.ok  = scan_in.ok && (!incl || late);
        scan_next.cnt = scan_in.cnt + CNT_W'(incl && hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
        end
    end

    assign scan_out = scan_reg;

endmodule

// File: sim/testbench.sv
module testbench;
    import kmac_pkg::*;

    localparam int unsigned PEERS        = 16;       // MAX_NODES of the instance
    localparam int unsigned LIMIT_CYCLES = 600000;
    localparam int unsigned PHASE_QUOTA  = 200;

    // one request as it goes onto the request pins
    typedef struct {
        mode_t       op;
        logic [3:0]  pid;
        logic [31:0] pclk;
        logic [1:0]  pch;
        logic [31:0] prt;
        logic        pact;
        logic [1:0]  rch;
        bit          drain;    // hold this request until every result is back
    } request_t;

    // what the block must report for one request
    typedef struct {
        logic        granted;
        logic [31:0] clock;
        logic        send;
        logic        pending;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  mode = '0;
    logic [3:0]  peer_id = '0;
    logic [31:0] peer_clock = '0;
    logic [1:0]  peer_channel = '0;
    logic [31:0] peer_request_time = '0;
    logic        peer_active = 1'b0;
    logic [1:0]  request_channel = '0;
    logic        done;
    logic        granted;
    logic [31:0] clock_value;
    logic        send_state;
    logic        pending;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    k_mutex_admission_check_top #(
        .MAX_NODES    (PEERS),
        .NUM_CHANNELS (4)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .mode              (mode),
        .peer_id           (peer_id),
        .peer_clock        (peer_clock),
        .peer_channel      (peer_channel),
        .peer_request_time (peer_request_time),
        .peer_active       (peer_active),
        .request_channel   (request_channel),
        .done              (done),
        .granted           (granted),
        .clock_value       (clock_value),
        .send_state        (send_state),
        .pending           (pending),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: Lamport clock, own request, peer table and
    // the register copy. Updated at the edge that accepts each request.
    // ------------------------------------------------------------------
    logic [31:0] lclock;
    logic [1:0]  my_channel;
    logic [31:0] my_stamp;
    logic        my_waiting;
    logic [31:0] tbl_clock   [PEERS];
    logic [1:0]  tbl_channel [PEERS];
    logic [31:0] tbl_stamp   [PEERS];
    logic        tbl_active  [PEERS];
    logic [4:0]  cfg_nodes;
    logic [3:0]  cfg_self;
    logic [3:0]  cfg_cap [4];

    request_t    request_q [$];   // requests not yet on the pins
    verdict_t    verdict_q [$];   // results owed by the block, oldest first
    request_t    on_pins;
    int unsigned hold_cnt = 0;
    int unsigned idle_pct = 0;
    int unsigned error_count = 0;
    int unsigned results_seen = 0;
    int unsigned grant_cnt = 0;
    int unsigned queued = 0;
    int unsigned taken = 0;       // requests accepted by the block
    int unsigned settings_cnt = 0;
    int unsigned cycle_cnt = 0;

    // generator's running view of the clock, used to aim peer clocks
    logic [31:0] gclk;
    logic [31:0] gstamp;

    function automatic logic [31:0] clock_tick(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // Lamport receive rule: one past the larger clock
    function automatic logic [31:0] merge_clock(input logic [31:0] mine, input logic [31:0] msg);
        return clock_tick((msg > mine) ? msg : mine);
    endfunction

    function automatic logic admit_check();
        int unsigned span;
        int unsigned tally;
        span = (cfg_nodes > PEERS) ? PEERS : cfg_nodes;
        tally = 1;
        if (!my_waiting)
            return 1'b0;
        for (int i = 0; i < span; i++)
        begin
            if (i == cfg_self)
                continue;
            if (tbl_clock[i] <= my_stamp)
                return 1'b0;
            if (tbl_active[i] && tbl_channel[i] == my_channel && tbl_stamp[i] <= my_stamp)
                tally++;
        end
        return (tally <= cfg_cap[my_channel]);
    endfunction

    function automatic verdict_t predict_outcome(input request_t r);
        verdict_t v;
        v.send = 1'b0;
        case (r.op)
            MODE_PEER_STATE, MODE_PEER_REQ:
            begin
                lclock = merge_clock(lclock, r.pclk);
                tbl_clock[r.pid]   = r.pclk;
                tbl_channel[r.pid] = r.pch;
                tbl_stamp[r.pid]   = r.prt;
                tbl_active[r.pid]  = r.pact;
                if (r.op == MODE_PEER_REQ)
                begin
                    lclock = clock_tick(lclock);    // reply tick
                    v.send = 1'b1;
                end
            end
            MODE_OWN_REQ:
            begin
                my_channel = r.rch;
                lclock     = clock_tick(lclock);
                my_stamp   = lclock;
                my_waiting = 1'b1;
                v.send     = 1'b1;
            end
            default:
                my_waiting = 1'b0;
        endcase
        v.granted = admit_check();
        v.clock   = lclock;
        v.pending = my_waiting;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: a request goes onto the pins from the queue, stays
    // until start && !busy, then a random hold-off may follow.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                verdict_q.push_back(predict_outcome(on_pins));
                taken++;
                hold_cnt = ($urandom_range(99, 0) < idle_pct) ? $urandom_range(40, 1) : 0;
            end
            if (!start || !busy)
            begin
                if (hold_cnt > 0)
                begin
                    hold_cnt--;
                    start <= 1'b0;
                end
                else if (request_q.size() > 0 &&
                         !(request_q[0].drain && verdict_q.size() > 0))
                begin
                    on_pins = request_q.pop_front();
                    start             <= 1'b1;
                    mode              <= on_pins.op;
                    peer_id           <= on_pins.pid;
                    peer_clock        <= on_pins.pclk;
                    peer_channel      <= on_pins.pch;
                    peer_request_time <= on_pins.prt;
                    peer_active       <= on_pins.pact;
                    request_channel   <= on_pins.rch;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        error_count++;
        if (error_count <= 100)
            $display("ERROR t=%0t result %0d: %s got %0h want %0h",
                     $time, results_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Result monitor: done is a one-cycle strobe, checked field by field
    // against the oldest owed result.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (verdict_q.size() == 0)
                flag_mismatch("result with no request outstanding", clock_value, '0);
            else
            begin
                want = verdict_q.pop_front();
                if (want.granted)
                    grant_cnt++;
                if (granted !== want.granted)
                    flag_mismatch("granted", 32'(granted), 32'(want.granted));
                if (clock_value !== want.clock)
                    flag_mismatch("clock_value", clock_value, want.clock);
                if (send_state !== want.send)
                    flag_mismatch("send_state", 32'(send_state), 32'(want.send));
                if (pending !== want.pending)
                    flag_mismatch("pending", 32'(pending), 32'(want.pending));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("k_mutex_admission_check_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Register port: setup then access; written at the access edge.
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [4:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            ADDR_NODE_COUNT: cfg_nodes  = data[4:0];
            ADDR_SELF_ID:    cfg_self   = data[3:0];
            ADDR_CAP0:       cfg_cap[0] = data[3:0];
            ADDR_CAP1:       cfg_cap[1] = data[3:0];
            ADDR_CAP2:       cfg_cap[2] = data[3:0];
            ADDR_CAP3:       cfg_cap[3] = data[3:0];
            default: ;
        endcase
    endtask

    // upper data bits are junk on purpose, the block keeps only the field
    task automatic load_settings(input logic [4:0] nodes, input logic [3:0] self_v,
                                 input logic [3:0] c0, input logic [3:0] c1,
                                 input logic [3:0] c2, input logic [3:0] c3);
        apb_write(ADDR_NODE_COUNT, {27'($urandom), nodes});
        apb_write(ADDR_SELF_ID,    {28'($urandom), self_v});
        apb_write(ADDR_CAP0,       {28'($urandom), c0});
        apb_write(ADDR_CAP1,       {28'($urandom), c1});
        apb_write(ADDR_CAP2,       {28'($urandom), c2});
        apb_write(ADDR_CAP3,       {28'($urandom), c3});
        settings_cnt++;
    endtask

    // wait until the block is idle with nothing owed, then a short pause
    task automatic settle();
        while (taken != queued || verdict_q.size() != 0)
            @(posedge clk);
        repeat (PEERS + 4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic request_t any_request();
        request_t r;
        r.op    = mode_t'($urandom_range(3, 0));
        r.pid   = 4'($urandom);
        r.pclk  = $urandom;
        r.pch   = 2'($urandom);
        r.prt   = $urandom;
        r.pact  = 1'($urandom);
        r.rch   = 2'($urandom);
        r.drain = 1'b0;
        return r;
    endfunction

    function automatic request_t peer_note(input mode_t op, input logic [3:0] id,
                                           input logic [31:0] clk_v, input logic [1:0] ch,
                                           input logic [31:0] rt, input logic act);
        request_t r;
        r      = any_request();
        r.op   = op;
        r.pid  = id;
        r.pclk = clk_v;
        r.pch  = ch;
        r.prt  = rt;
        r.pact = act;
        return r;
    endfunction

    // own request or release; peer fields left random, the block ignores them
    function automatic request_t own_note(input mode_t op, input logic [1:0] ch);
        request_t r;
        r     = any_request();
        r.op  = op;
        r.rch = ch;
        return r;
    endfunction

    function automatic logic [31:0] ahead(input int unsigned lo, input int unsigned hi);
        logic [32:0] sum;
        sum = {1'b0, gclk} + 33'($urandom_range(hi, lo));
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic logic [31:0] behind(input int unsigned span);
        logic [31:0] d;
        d = $urandom_range(span, 0);
        return (d > gclk) ? 32'd0 : gclk - d;
    endfunction

    // peer request times cluster around our own stamp so ties and near misses occur
    function automatic logic [31:0] peer_stamp();
        int unsigned pick;
        pick = $urandom_range(9, 0);
        if (pick < 6)
            return gstamp + 32'($urandom_range(6, 0)) - 32'd3;
        else if (pick < 8)
            return $urandom;
        else
            return ahead(0, 5);
    endfunction

    function automatic logic [3:0] pick_cap();
        return ($urandom_range(7, 0) == 0) ? 4'd15 : 4'($urandom_range(4, 0));
    endfunction

    task automatic push_req(input request_t r);
        request_q.push_back(r);
        queued++;
        case (r.op)
            MODE_PEER_STATE: gclk = merge_clock(gclk, r.pclk);
            MODE_PEER_REQ:   gclk = clock_tick(merge_clock(gclk, r.pclk));
            MODE_OWN_REQ:
            begin
                gclk   = clock_tick(gclk);
                gstamp = gclk;
            end
            default: ;
        endcase
    endtask

    // well-formed round: own request, peers answer (mostly past our stamp),
    // sometimes a restart, usually a release
    task automatic admission_round();
        int unsigned span;
        int unsigned rot;
        int unsigned id;
        logic [31:0] pc;
        request_t    r;
        span = (cfg_nodes > PEERS) ? PEERS : cfg_nodes;
        rot  = $urandom_range(15, 0);
        r = own_note(MODE_OWN_REQ, 2'($urandom));
        r.drain = ($urandom_range(9, 0) == 0);
        push_req(r);
        for (int i = 0; i < span; i++)
        begin
            id = (i + rot) % span;
            if (id == cfg_self || $urandom_range(19, 0) == 0)
                continue;
            pc = ($urandom_range(9, 0) == 0) ? gstamp - 32'($urandom_range(3, 0))
                                             : ahead(1, 6);
            push_req(peer_note($urandom_range(1, 0) ? MODE_PEER_REQ : MODE_PEER_STATE,
                               4'(id), pc,
                               $urandom_range(1, 0) ? r.rch : 2'($urandom),
                               peer_stamp(), 1'($urandom)));
        end
        if ($urandom_range(6, 0) == 0)
        begin
            push_req(own_note(MODE_OWN_REQ, 2'($urandom)));
            repeat ($urandom_range(3, 1))
                push_req(peer_note(MODE_PEER_STATE, 4'($urandom), ahead(1, 4),
                                   2'($urandom), peer_stamp(), 1'($urandom)));
        end
        if ($urandom_range(4, 0) != 0)
            push_req(own_note(MODE_OWN_REL, 2'($urandom)));
        if ($urandom_range(9, 0) == 0)
            push_req(own_note(MODE_OWN_REL, 2'($urandom)));
    endtask

    // a few unstructured requests; full-range peer clocks only when wide
    task automatic noise_round(input bit wide);
        request_t r;
        repeat ($urandom_range(4, 1))
        begin
            r = any_request();
            if (!wide)
                r.pclk = $urandom_range(1, 0) ? ahead(0, 8) : behind(60);
            push_req(r);
        end
    endtask

    // refill the queue a round at a time once everything queued has been taken,
    // so the generator's clock view starts from the exact shadow clock
    task automatic run_phase(input int unsigned quota, input bit wide);
        int unsigned goal;
        goal = queued + quota;
        while (queued < goal)
        begin
            while (taken != queued)
                @(posedge clk);
            gclk   = lclock;
            gstamp = my_stamp;
            if ($urandom_range(9, 0) < 7)
                admission_round();
            else
                noise_round(wide);
        end
        settle();
    endtask

    int unsigned idle_plan [4] = '{0, 57, 0, 35};

    initial
    begin
        request_t r;
        lclock     = '0;
        my_channel = '0;
        my_stamp   = '0;
        my_waiting = 1'b0;
        for (int i = 0; i < PEERS; i++)
        begin
            tbl_clock[i]   = '0;
            tbl_channel[i] = '0;
            tbl_stamp[i]   = '0;
            tbl_active[i]  = 1'b0;
        end
        cfg_nodes = 5'd1;
        cfg_self  = 4'd0;
        for (int i = 0; i < 4; i++)
            cfg_cap[i] = 4'd1;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings: only this node takes part, capacity 1.
        idle_pct = 0;
        gclk     = lclock;
        gstamp   = my_stamp;
        push_req(own_note(MODE_OWN_REL, 2'd0));                   // release while idle
        push_req(own_note(MODE_OWN_REQ, 2'd0));                   // alone: granted
        push_req(own_note(MODE_OWN_REQ, 2'd3));                   // restart while pending
        push_req(peer_note(MODE_PEER_STATE, 4'd15, ahead(0, 2), 2'd3,
                           32'hFFFF_FFFF, 1'b1));                 // outside the scan
        push_req(peer_note(MODE_PEER_REQ, 4'd0, 32'd0, 2'd0,
                           32'd0, 1'b0));                          // own slot: stored, unused
        push_req(own_note(MODE_OWN_REL, 2'd1));
        push_req(own_note(MODE_OWN_REL, 2'd2));
        settle();

        // Directed, three nodes, self in the middle, capacities 2/0/1/15.
        load_settings(5'd3, 4'd1, 4'd2, 4'd0, 4'd1, 4'd15);
        gclk   = lclock;
        gstamp = my_stamp;
        r = own_note(MODE_OWN_REQ, 2'd1);                         // capacity zero
        r.drain = 1'b1;
        push_req(r);
        push_req(peer_note(MODE_PEER_STATE, 4'd0, ahead(1, 1), 2'd1, gstamp, 1'b0));
        push_req(peer_note(MODE_PEER_STATE, 4'd2, ahead(1, 1), 2'd2, gstamp, 1'b0));
        push_req(own_note(MODE_OWN_REQ, 2'd0));
        push_req(peer_note(MODE_PEER_STATE, 4'd0, ahead(1, 3), 2'd0, gstamp, 1'b1));  // tie
        push_req(peer_note(MODE_PEER_REQ, 4'd2, ahead(1, 3), 2'd0,
                           gstamp - 32'd1, 1'b1));                // three contenders
        push_req(peer_note(MODE_PEER_STATE, 4'd2, ahead(1, 3), 2'd0,
                           gstamp - 32'd1, 1'b0));                // inactive: fits
        push_req(peer_note(MODE_PEER_STATE, 4'd1, 32'd0, 2'd0, 32'd0, 1'b1));
        push_req(peer_note(MODE_PEER_STATE, 4'd0, gstamp, 2'd0, gstamp, 1'b1)); // clock equal
        push_req(peer_note(MODE_PEER_STATE, 4'd0, ahead(1, 2), 2'd3, gstamp, 1'b1));
        push_req(own_note(MODE_OWN_REQ, 2'd3));
        push_req(peer_note(MODE_PEER_REQ, 4'd0, ahead(1, 2), 2'd3, gstamp, 1'b1));
        push_req(peer_note(MODE_PEER_REQ, 4'd2, ahead(1, 2), 2'd3, 32'd0, 1'b1));
        push_req(own_note(MODE_OWN_REQ, 2'd2));
        push_req(peer_note(MODE_PEER_STATE, 4'd0, ahead(1, 2), 2'd2,
                           gstamp + 32'd1, 1'b1));                // later request: not counted
        push_req(peer_note(MODE_PEER_STATE, 4'd2, ahead(1, 2), 2'd2, gstamp, 1'b0));
        push_req(own_note(MODE_OWN_REL, 2'd0));
        settle();

        // Random phases over a spread of register settings and idling.
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: load_settings(5'd16, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15);
                1: load_settings(5'd0, 4'd7, 4'd1, 4'd0, 4'd1, 4'd0);     // no peers scanned
                2: load_settings(5'd31, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4);    // clamps to 16
                3: load_settings(5'd4, 4'd2, 4'd2, 4'd1, 4'd0, 4'd3);
                default: load_settings(5'($urandom_range(9, 1)), 4'($urandom),
                                       pick_cap(), pick_cap(), pick_cap(), pick_cap());
            endcase
            idle_pct = idle_plan[p % 4];
            run_phase(PHASE_QUOTA, 1'b0);
        end

        // Full-range peer clocks, then drive the clock into saturation.
        load_settings(5'd5, 4'd3, pick_cap(), pick_cap(), pick_cap(), pick_cap());
        idle_pct = idle_plan[3];
        run_phase(150, 1'b1);
        gclk   = lclock;
        gstamp = my_stamp;
        push_req(peer_note(MODE_PEER_STATE, 4'd0, 32'hFFFF_FFFE, 2'd0, 32'hFFFF_FFFF, 1'b1));
        push_req(peer_note(MODE_PEER_REQ, 4'd1, 32'hFFFF_FFFF, 2'd1, 32'd0, 1'b0));
        push_req(own_note(MODE_OWN_REQ, 2'd0));                   // stamp stuck at max
        push_req(peer_note(MODE_PEER_STATE, 4'd2, 32'hFFFF_FFFF, 2'd0, 32'hFFFF_FFFF, 1'b1));
        push_req(own_note(MODE_OWN_REL, 2'd0));
        run_phase(40, 1'b1);

        $display("Run covered %0d requests under %0d register settings; %0d grants, %0d results.",
                 queued, settings_cnt, grant_cnt, results_seen);
        $display("Final logical clock %08h, mismatches %0d.", lclock, error_count);
        if (error_count == 0)
            $display("k_mutex_admission_check_top test passed");
        else
            $display("k_mutex_admission_check_top test failed");
        $finish;
    end

endmodule

// File: k_mutex_admission_check_top.f
+incdir+hdl
hdl/kmac_pkg.sv
hdl/kmac_cell.sv
hdl/k_mutex_admission_check_top.sv
sim/testbench.sv
